### sv/key_value_config_tokenizer_macros.svh
// Assertion macros for the tokenizer.
`ifndef KEY_VALUE_CONFIG_TOKENIZER_MACROS_SVH
`define KEY_VALUE_CONFIG_TOKENIZER_MACROS_SVH

// Same-cycle implication.
`define KVCT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define KVCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/kvct_pkg.sv
package kvct_pkg;

	localparam int unsigned ModeW = 3;

	localparam logic [ModeW-1:0] MODE_IDLE    = 3'd0;
	localparam logic [ModeW-1:0] MODE_COMMENT = 3'd1;
	localparam logic [ModeW-1:0] MODE_BARE    = 3'd2;
	localparam logic [ModeW-1:0] MODE_QUOTED  = 3'd3;
	localparam logic [ModeW-1:0] MODE_ESCAPE  = 3'd4;

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		logic       item_kind;
		logic [7:0] token_char;
		logic       token_role;
		logic       pair_done;
		logic       aborted;
	} kvct_result_t;

	function automatic logic is_token_byte(input logic [7:0] c);
		is_token_byte = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDER);
	endfunction

endpackage

### sv/kvct_lexer.sv
module kvct_lexer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           text_byte,
	input  logic                 end_of_text,
	output logic                 res_valid,
	output kvct_pkg::kvct_result_t res
);
	import kvct_pkg::*;

	logic [ModeW-1:0] mode_q, mode_d;
	logic             ev_q, ev_d;
	logic             tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			ev_q   <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			ev_q   <= ev_d;
		end
	end

	always_comb begin
		tok       = is_token_byte(text_byte);
		mode_d    = mode_q;
		ev_d      = ev_q;
		res_valid = 1'b0;
		res       = '{item_kind: KIND_CHAR, token_char: text_byte, token_role: ev_q,
			pair_done: 1'b0, aborted: 1'b0};
		if (end_of_text) begin
			res.item_kind  = KIND_END;
			res.token_char = 8'h00;
			if (mode_q == MODE_BARE) begin
				res_valid     = 1'b1;
				res.pair_done = ev_q;
			end else if (mode_q == MODE_QUOTED || mode_q == MODE_ESCAPE) begin
				res_valid   = 1'b1;
				res.aborted = 1'b1;
			end
			mode_d = MODE_IDLE;
			ev_d   = 1'b0;
		end else begin
			unique case (mode_q)
				MODE_COMMENT: begin
					if (text_byte == CH_CR || text_byte == CH_LF)
						mode_d = MODE_IDLE;
				end
				MODE_BARE: begin
					res_valid = 1'b1;
					if (!tok) begin
						res.item_kind  = KIND_END;
						res.token_char = 8'h00;
						res.pair_done  = ev_q;
						ev_d           = 1'b0;
						priority if (text_byte == CH_HASH)
							mode_d = MODE_COMMENT;
						else if (text_byte == CH_DQUOTE)
							mode_d = MODE_QUOTED;
						else if (text_byte == CH_EQUAL)
							ev_d = 1'b1;
						else
							mode_d = MODE_IDLE;
					end
				end
				MODE_QUOTED: begin
					priority if (text_byte == CH_DQUOTE) begin
						res_valid      = 1'b1;
						res.item_kind  = KIND_END;
						res.token_char = 8'h00;
						res.pair_done  = ev_q;
						ev_d           = 1'b0;
						mode_d         = MODE_IDLE;
					end else if (text_byte == CH_BSLASH) begin
						mode_d = MODE_ESCAPE;
					end else begin
						res_valid = 1'b1;
					end
				end
				MODE_ESCAPE: begin
					res_valid = (text_byte == CH_BSLASH) || (text_byte == CH_DQUOTE) ||
						(text_byte == CH_SQUOTE);
					mode_d    = MODE_QUOTED;
				end
				default: begin
					priority if (text_byte == CH_HASH)
						mode_d = MODE_COMMENT;
					else if (text_byte == CH_DQUOTE)
						mode_d = MODE_QUOTED;
					else if (text_byte == CH_EQUAL)
						ev_d = 1'b1;
					else if (tok) begin
						mode_d    = MODE_BARE;
						res_valid = 1'b1;
					end else
						mode_d = MODE_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/kvct_out_buf.sv
module kvct_out_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  kvct_pkg::kvct_result_t push_word,
	output logic                   full,
	output logic                   out_valid,
	input  logic                   out_stall,
	output kvct_pkg::kvct_result_t out_word
);
	import kvct_pkg::*;

	logic         main_v_q, skid_v_q;
	kvct_result_t main_q, skid_q;
	logic         pop;

	assign pop       = main_v_q && !out_stall;
	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign out_word  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop)
				skid_v_q <= 1'b0;
		end else if (push) begin
			if (main_v_q && !pop)
				skid_v_q <= 1'b1;
			else
				main_v_q <= 1'b1;
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop)
				main_q <= skid_q;
		end else if (push) begin
			if (main_v_q && !pop)
				skid_q <= push_word;
			else
				main_q <= push_word;
		end
	end

endmodule

### sv/key_value_config_tokenizer.sv
// A result word is formed combinationally from its accepted input word and is registered in the output buffer first.
// Throughput: one input word per cycle while in_stall is low; the lexer state updates on each accepted word.
// A two-entry output buffer keeps input flowing while one result waits to be taken.
// Reset (arst_n low, asynchronous): lexer idle, expecting a name, output buffer empty.
`include "key_value_config_tokenizer_macros.svh"

module key_value_config_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       item_kind,
	output logic [7:0] token_char,
	output logic       token_role,
	output logic       pair_done,
	output logic       aborted
);
	import kvct_pkg::*;

	logic         accept;
	logic         res_valid;
	kvct_result_t res, out_word;

	assign accept = in_valid && !in_stall;

	kvct_lexer u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.res_valid  (res_valid),
		.res        (res)
	);

	kvct_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_word (res),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	assign item_kind  = out_word.item_kind;
	assign token_char = out_word.token_char;
	assign token_role = out_word.token_role;
	assign pair_done  = out_word.pair_done;
	assign aborted    = out_word.aborted;

	`KVCT_ASSERT_IMPL(a_skid_implies_main, clk, arst_n, in_stall, out_valid, "skid full with main empty")
	`KVCT_ASSERT_IMPL(a_char_no_flags, clk, arst_n, out_valid && item_kind == KIND_CHAR, !pair_done && !aborted, "flags set on char word")
	`KVCT_ASSERT_IMPL(a_abort_no_pair, clk, arst_n, out_valid && aborted, !pair_done && item_kind == KIND_END, "aborted word completes pair")
	`KVCT_ASSERT_IMPL(a_end_char_zero, clk, arst_n, out_valid && item_kind == KIND_END, token_char == 8'h00, "end word carries a character")

endmodule

### test/key_value_config_tokenizer_checker.sv
`timescale 1ns / 1ps

module key_value_config_tokenizer_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       item_kind,
	input  logic [7:0] token_char,
	input  logic       token_role,
	input  logic       pair_done,
	input  logic       aborted,
	output int         fails,
	output int         pending,
	output int         words_out,
	output int         pairs_seen,
	output int         cuts_seen
);
	import kvct_pkg::*;

	logic [ModeW-1:0] lex_mode;
	logic             want_value;
	kvct_result_t     token_q[$];

	function automatic logic is_word_char(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER};
	endfunction

	function automatic kvct_result_t char_word(input logic [7:0] c);
		return '{KIND_CHAR, c, want_value, 1'b0, 1'b0};
	endfunction

	task automatic close_token(input logic cut, output kvct_result_t r);
		r = '{KIND_END, 8'h00, want_value, want_value & ~cut, cut};
		if (want_value && !cut)
			want_value = 1'b0;
	endtask

	// '=' leaves the mode as it is
	task automatic skip_between(input logic [7:0] c);
		if (c == CH_HASH)
			lex_mode = MODE_COMMENT;
		else if (c == CH_DQUOTE)
			lex_mode = MODE_QUOTED;
		else if (c == CH_EQUAL)
			want_value = 1'b1;
		else if (is_word_char(c))
			lex_mode = MODE_BARE;
		else
			lex_mode = MODE_IDLE;
	endtask

	task automatic advance_lexer(input logic [7:0] c, input logic eot, output bit produced,
			output kvct_result_t r);
		produced = 1'b0;
		r = '0;
		if (eot) begin
			if (lex_mode == MODE_BARE) begin
				close_token(1'b0, r);
				produced = 1'b1;
			end else if (lex_mode == MODE_QUOTED || lex_mode == MODE_ESCAPE) begin
				close_token(1'b1, r);
				produced = 1'b1;
			end
			lex_mode = MODE_IDLE;
			want_value = 1'b0;
		end else begin
			case (lex_mode)
				MODE_COMMENT: begin
					if (c == CH_CR || c == CH_LF)
						lex_mode = MODE_IDLE;
				end
				MODE_BARE: begin
					produced = 1'b1;
					if (is_word_char(c)) begin
						r = char_word(c);
					end else begin
						close_token(1'b0, r);
						skip_between(c);
					end
				end
				MODE_QUOTED: begin
					if (c == CH_DQUOTE) begin
						close_token(1'b0, r);
						produced = 1'b1;
						lex_mode = MODE_IDLE;
					end else if (c == CH_BSLASH) begin
						lex_mode = MODE_ESCAPE;
					end else begin
						r = char_word(c);
						produced = 1'b1;
					end
				end
				MODE_ESCAPE: begin
					if (c == CH_BSLASH || c == CH_DQUOTE || c == CH_SQUOTE) begin
						r = char_word(c);
						produced = 1'b1;
					end
					lex_mode = MODE_QUOTED;
				end
				default: begin
					skip_between(c);
					if (lex_mode == MODE_BARE) begin
						r = char_word(c);
						produced = 1'b1;
					end
				end
			endcase
		end
	endtask

	always @(posedge clk) begin
		kvct_result_t got, want, predicted;
		bit made;
		if (!arst_n) begin
			lex_mode = MODE_IDLE;
			want_value = 1'b0;
			token_q.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{item_kind, token_char, token_role, pair_done, aborted};
				words_out++;
				if (token_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%t: unexpected word kind=%0d char=%02h role=%0d pair=%0d abort=%0d",
							$realtime, got.item_kind, got.token_char, got.token_role,
							got.pair_done, got.aborted);
				end else begin
					want = token_q.pop_front();
					if (got.item_kind !== want.item_kind || got.token_char !== want.token_char ||
							got.token_role !== want.token_role ||
							got.pair_done !== want.pair_done || got.aborted !== want.aborted) begin
						fails++;
						if (fails <= 10)
							$display({"%t: mismatch exp kind=%0d char=%02h role=%0d pair=%0d ",
								"abort=%0d, got kind=%0d char=%02h role=%0d pair=%0d abort=%0d"},
								$realtime, want.item_kind, want.token_char, want.token_role,
								want.pair_done, want.aborted, got.item_kind, got.token_char,
								got.token_role, got.pair_done, got.aborted);
					end
				end
				if (got.pair_done === 1'b1)
					pairs_seen++;
				if (got.aborted === 1'b1)
					cuts_seen++;
			end
			if (in_valid && !in_stall) begin
				advance_lexer(text_byte, end_of_text, made, predicted);
				if (made)
					token_q.push_back(predicted);
			end
			pending = token_q.size();
		end
	end

endmodule

### test/tb_key_value_config_tokenizer.sv
`timescale 1ns / 1ps

module tb_key_value_config_tokenizer;
	import kvct_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_LEN    = 200;
	localparam int PHASE_WORDS = 270;

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
	} text_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] text_byte = 8'h00;
	logic       end_of_text = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       item_kind;
	logic [7:0] token_char;
	logic       token_role;
	logic       pair_done;
	logic       aborted;

	int fails, pending, words_out, pairs_seen, cuts_seen;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int bytes_sent = 0;
	int quiet = 0;

	text_word_t text_q[$];

	key_value_config_tokenizer dut (.*);

	key_value_config_tokenizer_checker tok_check (.*);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		if (hold_taken != hold_req) begin
			hold_taken = hold_req;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		text_q.push_back('{b, 1'b0});
	endtask

	task automatic push_eot();
		text_q.push_back('{8'($urandom_range(255)), 1'b1});
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	function automatic logic [7:0] name_char();
		int r;
		r = $urandom_range(62);
		if (r < 10)
			return 8'(8'h30 + r);
		else if (r < 36)
			return 8'(8'h41 + r - 10);
		else if (r < 62)
			return 8'(8'h61 + r - 36);
		return CH_UNDER;
	endfunction

	task automatic gen_bare();
		repeat ($urandom_range(1, 6))
			push_byte(name_char());
	endtask

	task automatic gen_blank();
		logic [7:0] pick[4] = '{8'h20, 8'h09, CH_CR, CH_LF};
		repeat ($urandom_range(2))
			push_byte(pick[$urandom_range(3)]);
	endtask

	// quoted string; left open once in a while
	task automatic gen_quoted(input bit open_end);
		logic [7:0] b;
		logic [7:0] esc[4];
		push_byte(CH_DQUOTE);
		repeat ($urandom_range(8)) begin
			if ($urandom_range(9) < 2) begin
				esc = '{CH_BSLASH, CH_DQUOTE, CH_SQUOTE, 8'($urandom_range(255))};
				push_byte(CH_BSLASH);
				push_byte(esc[$urandom_range(3)]);
			end else begin
				do b = 8'($urandom_range(255)); while (b == CH_DQUOTE || b == CH_BSLASH);
				push_byte(b);
			end
		end
		if (!open_end)
			push_byte(CH_DQUOTE);
	endtask

	task automatic gen_pair();
		logic [7:0] ends[4] = '{CH_LF, 8'h20, CH_CR, 8'h3B};
		gen_blank();
		gen_bare();
		gen_blank();
		push_byte(CH_EQUAL);
		gen_blank();
		if ($urandom_range(1))
			gen_bare();
		else
			gen_quoted($urandom_range(9) == 0);
		push_byte(ends[$urandom_range(3)]);
	endtask

	task automatic gen_comment();
		logic [7:0] b;
		push_byte(CH_HASH);
		repeat ($urandom_range(10)) begin
			do b = 8'($urandom_range(255)); while (b == CH_CR || b == CH_LF);
			push_byte(b);
		end
		push_byte($urandom_range(1) ? CH_CR : CH_LF);
	endtask

	task automatic gen_chunk();
		int r;
		r = $urandom_range(99);
		if (r < 65) begin
			gen_pair();
		end else if (r < 75) begin
			gen_comment();
		end else if (r < 85) begin
			repeat ($urandom_range(1, 4))
				push_byte(8'($urandom_range(255)));
		end else if (r < 92) begin
			push_eot();
		end else begin
			gen_bare();
			push_byte(CH_EQUAL);
			gen_quoted(1'b1);
			if ($urandom_range(1))
				push_byte(CH_BSLASH);
			push_eot();
		end
	endtask

	task automatic send_text();
		text_word_t w;
		while (text_q.size() != 0) begin
			w = text_q.pop_front();
			while ($urandom_range(99) < idle_pct) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
			in_valid <= 1'b1;
			text_byte <= w.ch;
			end_of_text <= w.eot;
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			bytes_sent++;
			@(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input int idle, input int stall, input bit long_hold);
		int start;
		idle_pct = idle;
		stall_pct = stall;
		start = bytes_sent;
		if (long_hold) begin
			hold_req++;
			repeat (6)
				gen_pair();
			send_text();
		end
		while (bytes_sent - start < PHASE_WORDS) begin
			gen_chunk();
			send_text();
		end
		drain();
	endtask

	initial begin
		repeat (9)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_text("k==\"");
		push_byte(8'hFF);
		push_text("\\\"\\\\\\");
		push_byte(CH_SQUOTE);
		push_text("\\q\"");
		push_text("#\"\nZ");
		push_byte(8'h00);
		push_text("9\"\\");
		push_eot();
		push_text("_#x");
		push_byte(CH_CR);
		push_text("=a");
		push_eot();
		push_eot();
		send_text();
		drain();

		run_phase(0, 0, 1'b1);
		run_phase(47, 0, 1'b0);
		run_phase(0, 47, 1'b0);
		run_phase(8, 8, 1'b0);

		stall_pct = 0;
		repeat (10)
			@(negedge clk);

		$display("Sent %0d text words and checked %0d result words, %0d completed pairs",
			bytes_sent, words_out, pairs_seen);
		$display("and %0d cut strings, under four idle/stall mixes and a long output hold.",
			cuts_seen);
		if (fails == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
